// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fir46_pkg.sv =====
`timescale 1ns / 1ps
package fir46_pkg;

  localparam int DC_W       = 12;
  localparam int CENTER_W   = 13;
  localparam int FILT_W     = 14;
  localparam int SLOT_OUT_W = 7;

  localparam logic [DC_W-1:0] DC_RESET = 12'd2048;

  localparam int TABLE_LEN  = 46;
  localparam int TABLE_FRAC = 15;
  localparam int OUT_MIN    = -8192;
  localparam int OUT_MAX    = 8191;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SHIFT,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  // Low-pass table in Q1.15; taps past the table read as zero.
  function automatic logic signed [15:0] coef_q15(input int j);
    case (j)
      0:  return -16'sd48;
      1:  return -16'sd89;
      2:  return -16'sd80;
      3:  return 16'sd0;
      4:  return 16'sd124;
      5:  return 16'sd212;
      6:  return 16'sd180;
      7:  return 16'sd0;
      8:  return -16'sd254;
      9:  return -16'sd423;
      10: return -16'sd350;
      11: return 16'sd0;
      12: return 16'sd479;
      13: return 16'sd792;
      14: return 16'sd657;
      15: return 16'sd0;
      16: return -16'sd925;
      17: return -16'sd1582;
      18: return -16'sd1383;
      19: return 16'sd0;
      20: return 16'sd2407;
      21: return 16'sd5176;
      22: return 16'sd7380;
      23: return 16'sd8219;
      24: return 16'sd7380;
      25: return 16'sd5176;
      26: return 16'sd2407;
      27: return 16'sd0;
      28: return -16'sd1383;
      29: return -16'sd1582;
      30: return -16'sd925;
      31: return 16'sd0;
      32: return 16'sd657;
      33: return 16'sd792;
      34: return 16'sd479;
      35: return 16'sd0;
      36: return -16'sd350;
      37: return -16'sd423;
      38: return -16'sd254;
      39: return 16'sd0;
      40: return 16'sd180;
      41: return 16'sd212;
      42: return 16'sd124;
      43: return 16'sd0;
      44: return -16'sd80;
      45: return -16'sd89;
      default: return 16'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/fir_lowpass_46_tap_unit.sv =====
`timescale 1ns / 1ps
// Low-pass FIR, TAPS taps, for unsigned converter samples.
// Input channel: in_valid / in_ready with raw_sample. One transaction is one
//   sample. The programmed dc_offset is subtracted on acceptance.
// Output channel: out_valid / out_ready with centered_sample, filtered_sample
//   (rounded, saturated to 14 bits) and slot_index (counts 0..SLOTS-1, wraps).
// Config: cfg_we writes cfg_data into dc_offset at the clock edge; only
//   write while no sample is in flight.
// Sequence: after acceptance the block runs one multiply-accumulate step per tap
//   (ST_MAC), a shift step (ST_SHIFT), a drain of the multiply pipeline
//   (ST_DRAIN) and a round-and-load step (ST_ROUND) that raises out_valid. The
//   delay line rotates one word per cycle past a single multiply-accumulate
//   unit. A new sample is taken only in the idle state, so the block does not
//   take a new sample before it is through with the last one.
// Stall: the result sits in an output register. The next sample may be taken
//   and filtered while it waits; the block then holds before loading the new
//   result until the old transaction completes.
// Reset (rst, synchronous, active high): delay line and slot counter clear,
//   dc_offset returns to 2048, no result is pending.
module fir_lowpass_46_tap_unit #(
  parameter int TAPS           = 46,
  parameter int SLOTS          = 128,
  parameter int SAMPLE_BITS    = 12,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [fir46_pkg::DC_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [SAMPLE_BITS-1:0]                 raw_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fir46_pkg::CENTER_W-1:0]  centered_sample,
  output logic signed [fir46_pkg::FILT_W-1:0]    filtered_sample,
  output logic [fir46_pkg::SLOT_OUT_W-1:0]       slot_index
);
  import fir46_pkg::*;

  // Sample width after centering.
  localparam int X_W     = ((SAMPLE_BITS > DC_W) ? SAMPLE_BITS : DC_W) + 1;
  localparam int LSH     = (COEF_FRAC_BITS > TABLE_FRAC) ? COEF_FRAC_BITS - TABLE_FRAC : 0;
  localparam int RSH     = (COEF_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - COEF_FRAC_BITS : 0;
  localparam int COEF_W  = (COEF_FRAC_BITS > TABLE_FRAC) ? COEF_FRAC_BITS + 1 : 16;
  localparam int PROD_W  = COEF_W + X_W;
  localparam int ACC_W   = PROD_W + $clog2(TAPS);
  localparam int TAP_W   = $clog2(TAPS);
  localparam int LINE_N  = TAPS - 1;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam logic [TAP_W-1:0]  TAP_LAST  = TAP_W'(TAPS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [ACC_W:0]    RND_HALF  = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);

  // Rescale a table entry to COEF_FRAC_BITS, rounding half up on a right shift.
  function automatic logic signed [COEF_W-1:0] coef_scaled(input logic [TAP_W-1:0] j);
    logic signed [31:0] c;
    c = 32'(coef_q15(int'(j)));
    c = ((c <<< LSH) + ((32'sd1 <<< RSH) >>> 1)) >>> RSH;
    return COEF_W'(c);
  endfunction

  state_t state, state_next;

  logic [DC_W-1:0]         dc_offset;
  logic signed [X_W-1:0]   cur;
  logic signed [X_W-1:0]   cur_next;
  logic signed [X_W-1:0]   line [LINE_N];
  logic [TAP_W-1:0]        tap;
  logic [SLOT_W-1:0]       slot_cnt;
  logic [SLOT_W-1:0]       slot_q;

  logic signed [COEF_W-1:0] coef_r;
  logic signed [X_W-1:0]    opnd_r;
  logic                     s1_v;
  logic signed [PROD_W-1:0] prod;
  logic                     s2_v;
  logic signed [ACC_W-1:0]  acc;

  logic signed [ACC_W:0]    rsum;
  logic signed [ACC_W:0]    yq;
  logic signed [FILT_W-1:0] filt_next;

  logic in_fire;
  logic mac_en;
  logic shift_en;
  logic out_load;

  assign in_fire  = in_valid && in_ready;
  assign cur_next = $signed(X_W'(raw_sample)) - $signed(X_W'(dc_offset));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MAC;
      ST_MAC:   if (tap == TAP_LAST) state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_DRAIN;
      ST_DRAIN: if (!s1_v && !s2_v) state_next = ST_ROUND;
      ST_ROUND: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control decode.
  always_comb begin
    in_ready = 1'b0;
    mac_en   = 1'b0;
    shift_en = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_MAC:   mac_en   = 1'b1;
      ST_SHIFT: shift_en = 1'b1;
      ST_DRAIN: ;
      ST_ROUND: out_load = !out_valid || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Register and slot counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_offset <= DC_RESET;
      slot_cnt  <= '0;
    end else begin
      if (cfg_we) dc_offset <= cfg_data;
      if (in_fire) slot_cnt <= (slot_cnt == SLOT_LAST) ? '0 : slot_cnt + 1'b1;
    end
  end

  // Capture the sample and its slot; the tap count and accumulator clear on acceptance below.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur    <= cur_next;
      slot_q <= slot_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (in_fire) begin
      tap <= '0;
    end else if (mac_en && tap != TAP_LAST) begin
      tap <= tap + 1'b1;
    end
  end

  // Delay line: rotate one word per tap, then shift the new sample in.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_N; i++) line[i] <= '0;
    end else if (mac_en && tap != '0) begin
      for (int i = 0; i < LINE_N - 1; i++) line[i] <= line[i + 1];
      line[LINE_N - 1] <= line[0];
    end else if (shift_en) begin
      line[0] <= cur;
      for (int i = 1; i < LINE_N; i++) line[i] <= line[i - 1];
    end
  end

  // MAC pipeline: operand fetch, multiply, accumulate.
  always_ff @(posedge clk) begin
    coef_r <= coef_scaled(tap);
    opnd_r <= (tap == '0) ? cur : line[0];
    prod   <= coef_r * opnd_r;
    if (in_fire) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= mac_en;
      s2_v <= s1_v;
    end
  end

  // Round half up, then saturate to the output range.
  always_comb begin
    rsum = $signed((ACC_W + 1)'(acc)) + $signed(RND_HALF);
    yq   = rsum >>> COEF_FRAC_BITS;
    if (yq > $signed((ACC_W + 1)'(OUT_MAX))) begin
      filt_next = FILT_W'(OUT_MAX);
    end else if (yq < $signed((ACC_W + 1)'(OUT_MIN))) begin
      filt_next = FILT_W'(OUT_MIN);
    end else begin
      filt_next = FILT_W'(yq);
    end
  end

  // Output register: hold until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      centered_sample <= CENTER_W'(cur);
      filtered_sample <= filt_next;
      slot_index      <= SLOT_OUT_W'(slot_q);
    end
  end

endmodule

// ===== rtl/fir46_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fir46_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [fir46_pkg::CENTER_W-1:0]  centered_sample,
  input logic signed [fir46_pkg::FILT_W-1:0]    filtered_sample,
  input logic [fir46_pkg::SLOT_OUT_W-1:0]       slot_index
);
  import fir46_pkg::*;

  `ASSERT_CLK_NR(a_reset_idle, clk, rst |=> in_ready && !out_valid, "not idle after reset")
  `ASSERT_CLK(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "took two samples")
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(centered_sample) && $stable(filtered_sample) && $stable(slot_index), "stalled result changed")

endmodule

bind fir_lowpass_46_tap_unit fir46_chk u_fir46_chk (.*);
